// ----- rtl/core/gpmd_pkg.sv -----
// shared constants and types for the gf2 polynomial modular divider
`default_nettype none

package gpmd_pkg;

  // width of the polynomial arithmetic
  localparam int WIDTH = 64;
  // width of the payload ports
  localparam int FIELD_W = 64;
  // modulus after reset: x^8 + x^4 + x^3 + x + 1
  localparam logic [FIELD_W-1:0] MODULUS_RESET = FIELD_W'(283);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } gpmd_state_t;

  // sequencer commands to the datapath
  typedef struct packed {
    logic load;
    logic step;
  } gpmd_ctrl_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic u_zero;
    logic v_one;
  } gpmd_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/gpmd_datapath.sv -----
// working registers and the shared shift / xor step unit of the divider
`default_nettype none

module gpmd_datapath import gpmd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire gpmd_ctrl_t       ctrl,
  input  wire logic [WIDTH-1:0] mod_w,
  input  wire logic [WIDTH-1:0] load_u,
  input  wire logic [WIDTH-1:0] load_cu,
  output gpmd_status_t          status,
  output logic [WIDTH-1:0]      coef_v_out
);

  logic [WIDTH-1:0] work_u, work_u_next;
  logic [WIDTH-1:0] work_v, work_v_next;
  logic [WIDTH-1:0] coef_u, coef_u_next;
  logic [WIDTH-1:0] coef_v, coef_v_next;

  // divide a coefficient by x, adding the modulus first when it is odd
  function automatic logic [WIDTH-1:0] halve(input logic [WIDTH-1:0] c,
                                             input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] t;
    t = c[0] ? (c ^ m) : c;
    return t >> 1;
  endfunction

  // one step: strip factors of x, or let the larger value absorb the smaller
  always_comb begin
    work_u_next = work_u;
    work_v_next = work_v;
    coef_u_next = coef_u;
    coef_v_next = coef_v;
    if (ctrl.load) begin
      work_u_next = load_u;
      work_v_next = mod_w;
      coef_u_next = load_cu;
      coef_v_next = '0;
    end else if (ctrl.step && !status.u_zero) begin
      if (!work_u[0]) begin
        work_u_next = work_u >> 1;
        coef_u_next = halve(coef_u, mod_w);
      end
      if (!work_v[0]) begin
        work_v_next = work_v >> 1;
        coef_v_next = halve(coef_v, mod_w);
      end
      if (work_u[0] && work_v[0]) begin
        if (work_u >= work_v) begin
          work_u_next = work_u ^ work_v;
          coef_u_next = coef_u ^ coef_v;
        end else begin
          work_v_next = work_v ^ work_u;
          coef_v_next = coef_v ^ coef_u;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      work_u <= '0;
      work_v <= '0;
      coef_u <= '0;
      coef_v <= '0;
    end else begin
      work_u <= work_u_next;
      work_v <= work_v_next;
      coef_u <= coef_u_next;
      coef_v <= coef_v_next;
    end
  end

  // status to the sequencer
  assign status.u_zero = (work_u == '0);
  assign status.v_one  = (work_v == WIDTH'(1));
  assign coef_v_out    = coef_v;

  // a step never runs with work_v empty, since it starts odd and only takes smaller values
  a_v_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctrl.step && !status.u_zero |-> work_v != '0)
    else $error("work_v became zero during a step");

endmodule

`default_nettype wire

// ----- rtl/core/gf2_poly_mod_divide.sv -----
// top level of the gf2 polynomial modular divider
// Computes quotient = dividend * divisor^-1 mod modulus over GF(2) with the binary
// extended Euclidean algorithm; inversion is dividend = 1. A transfer is taken when
// start is high and busy is low. busy then stays high while one shared shift / xor
// step unit is applied once per cycle: each cycle strips one factor of x from each
// even working value, or xors the smaller into the larger. Every xor is followed by
// at least one shift, and every shift removes a bit from the two working values, so
// the loop always ends. The result appears on quotient and not_invertible for
// exactly one cycle with done high, in the same cycle that busy falls, and the
// receiver cannot stall it. A modulus with constant term 0 gives quotient 0 and
// not_invertible 1 in the cycle after the transfer. The user must write modulus
// through modulus_wr / modulus_data only while the block is idle; the block itself
// does not enforce this.
`default_nettype none

module gf2_poly_mod_divide import gpmd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               modulus_wr,
  input  wire logic [FIELD_W-1:0] modulus_data,
  input  wire logic               start,
  input  wire logic [FIELD_W-1:0] dividend,
  input  wire logic [FIELD_W-1:0] divisor,
  output logic                    busy,
  output logic                    done,
  output logic [FIELD_W-1:0]      quotient,
  output logic                    not_invertible
);

  gpmd_state_t       state, state_next;
  logic [FIELD_W-1:0] modulus;
  logic [WIDTH-1:0]  mod_w;
  gpmd_ctrl_t        ctrl;
  gpmd_status_t      status;
  logic [WIDTH-1:0]  coef_v;
  logic              accept;
  logic              even_mod;
  logic              finish;

  assign mod_w    = modulus[WIDTH-1:0];
  assign accept   = start && !busy;
  assign even_mod = !mod_w[0];
  assign finish   = (state == ST_RUN) && status.u_zero;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (modulus_wr) begin
      modulus <= modulus_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !even_mod) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.u_zero) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    case (state)
      ST_IDLE: ctrl.load = accept && !even_mod;
      ST_RUN:  ctrl.step = 1'b1;
      default: ctrl = '0;
    endcase
  end

  assign busy = (state != ST_IDLE);

  gpmd_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .mod_w      (mod_w),
    .load_u     (divisor[WIDTH-1:0]),
    .load_cu    (dividend[WIDTH-1:0]),
    .status     (status),
    .coef_v_out (coef_v)
  );

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish || (accept && even_mod);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (finish) begin
      not_invertible <= !status.v_one;
      quotient       <= status.v_one ? FIELD_W'(coef_v) : '0;
    end else if (accept && even_mod) begin
      not_invertible <= 1'b1;
      quotient       <= '0;
    end
  end

  // an accepted transfer either starts the loop or gives an immediate result
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy || done)
    else $error("accepted transfer produced neither work nor result");

  // the loop ends with one strobe and the block idle
  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    finish |=> done && !busy)
    else $error("loop end did not deliver a result");

  // a flagged result carries a zero quotient
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    done && not_invertible |-> quotient == '0)
    else $error("flagged result with nonzero quotient");

endmodule

`default_nettype wire

// ----- verif/gf2_poly_mod_divide_test.sv -----
// self-checking testbench for the gf2 polynomial modular divider
module gf2_poly_mod_divide_test;
  import gpmd_pkg::*;

  // silent cycles allowed before the run is declared hung
  localparam int QUIET_LIMIT = 4000;
  // drain time after the last expected result
  localparam int TAIL_CYCLES = 2 * WIDTH + 8;
  localparam logic [FIELD_W-1:0] ALL_ONES = {FIELD_W{1'b1}};

  typedef struct packed {
    logic [FIELD_W-1:0] quotient;
    logic               not_invertible;
  } division_t;

  // kinds of modulus used by the random phases
  typedef enum int {
    MOD_AES,
    MOD_ONES,
    MOD_SPARSE,
    MOD_ONE,
    MOD_ODD_FULL,
    MOD_ODD_DEG,
    MOD_EVEN,
    MOD_ZERO
  } modulus_kind_t;

  // predicts each quotient and checks the results in order
  class quotient_checker;
    logic [FIELD_W-1:0] modulus;
    division_t          pending[$];
    int                 mismatches;

    function new();
      modulus    = MODULUS_RESET;
      mismatches = 0;
    endfunction

    function void note_modulus(input logic [FIELD_W-1:0] m);
      modulus = m;
    endfunction

    // binary extended euclid: returns dividend * divisor^-1 mod modulus
    function division_t divide(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
      logic [FIELD_W-1:0] wmask;
      logic [FIELD_W-1:0] m;
      logic [FIELD_W-1:0] u;
      logic [FIELD_W-1:0] v;
      logic [FIELD_W-1:0] cu;
      logic [FIELD_W-1:0] cv;
      division_t          r;
      wmask = ALL_ONES >> (FIELD_W - WIDTH);
      m     = modulus & wmask;
      // even modulus is always flagged not invertible
      if (!m[0]) begin
        r.quotient       = '0;
        r.not_invertible = 1'b1;
        return r;
      end
      cu = a & wmask;
      cv = '0;
      u  = b & wmask;
      v  = m;
      while (u != '0) begin
        while (!u[0]) begin
          u  = u >> 1;
          cu = (cu[0] ? cu ^ m : cu) >> 1;
        end
        while (!v[0]) begin
          v  = v >> 1;
          cv = (cv[0] ? cv ^ m : cv) >> 1;
        end
        // larger magnitude absorbs the smaller
        if (u >= v) begin
          u  = u ^ v;
          cu = cu ^ cv;
        end else begin
          v  = v ^ u;
          cv = cv ^ cu;
        end
      end
      r.not_invertible = (v != FIELD_W'(1));
      r.quotient       = r.not_invertible ? '0 : (cv & wmask);
      return r;
    endfunction

    function void note_division(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
      pending.push_back(divide(a, b));
    endfunction

    function void check_quotient(input logic [FIELD_W-1:0] q, input logic flag);
      division_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: quotient %h not_invertible %b", $time, q, flag);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (q !== want.quotient) begin
        $display("%0t quotient mismatch: expected %h, actual %h", $time, want.quotient, q);
        mismatches++;
      end
      if (flag !== want.not_invertible) begin
        $display("%0t not_invertible mismatch: expected %b, actual %b",
                 $time, want.not_invertible, flag);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               modulus_wr;
  logic [FIELD_W-1:0] modulus_data;
  logic               start;
  logic [FIELD_W-1:0] dividend;
  logic [FIELD_W-1:0] divisor;
  logic               busy;
  logic               done;
  logic [FIELD_W-1:0] quotient;
  logic               not_invertible;

  quotient_checker board;
  int              burst_left;
  int              quiet_cycles;

  gf2_poly_mod_divide i_dut (
    .clk            (clk),
    .rst            (rst),
    .modulus_wr     (modulus_wr),
    .modulus_data   (modulus_data),
    .start          (start),
    .dividend       (dividend),
    .divisor        (divisor),
    .busy           (busy),
    .done           (done),
    .quotient       (quotient),
    .not_invertible (not_invertible)
  );

  // clock
  always #5 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) board.check_quotient(quotient, not_invertible);
  end

  // watchdog: no transfer for too long means a hang
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [FIELD_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // operand mostly reduced below the modulus, sometimes an edge value
  function automatic logic [FIELD_W-1:0] pick_operand(input logic [FIELD_W-1:0] m);
    logic [FIELD_W-1:0] below;
    int                 msb;
    msb = 0;
    for (int i = 0; i < FIELD_W; i++) begin
      if (m[i]) msb = i;
    end
    below = ALL_ONES >> (FIELD_W - msb);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return FIELD_W'(1);
      2:       return random_word();
      3:       return ALL_ONES;
      default: return random_word() & below;
    endcase
  endfunction

  // lower start and wait until every expected result is back
  task automatic wait_until_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (busy || board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic load_modulus(input logic [FIELD_W-1:0] m);
    wait_until_quiet();
    modulus_wr   <= 1'b1;
    modulus_data <= m;
    @(posedge clk);
    modulus_wr <= 1'b0;
    board.note_modulus(m);
  endtask

  // one division transfer, with bursts and random gaps
  task automatic issue_division(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 12);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start    <= 1'b1;
    dividend <= a;
    divisor  <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_division(a, b);
    burst_left--;
  endtask

  initial begin
    modulus_kind_t      kinds[12];
    logic [FIELD_W-1:0] m;
    int                 count;
    int                 deg;

    clk          = 1'b0;
    rst          = 1'b1;
    modulus_wr   = 1'b0;
    modulus_data = '0;
    start        = 1'b0;
    dividend     = '0;
    divisor      = '0;
    quiet_cycles = 0;
    burst_left   = 0;
    board        = new();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: modulus after reset, inversion, zero operands, unreduced operands
    issue_division(64'd1, 64'h53);
    issue_division(64'd0, 64'h53);
    issue_division(64'hCA, 64'd0);
    issue_division(64'hFF, 64'd1);
    issue_division(ALL_ONES, ALL_ONES);
    issue_division(64'h8000_0000_0000_0000, 64'h0000_0001_0000_0000);
    // all-ones modulus
    load_modulus(ALL_ONES);
    issue_division(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
    issue_division(64'd1, 64'd2);
    issue_division(64'h5555_5555_5555_5555, 64'd0);
    issue_division(ALL_ONES, 64'hAAAA_AAAA_AAAA_AAAA);
    // modulus one: zero divisor still gives a clean zero
    load_modulus(64'd1);
    issue_division(64'd0, 64'd0);
    issue_division(ALL_ONES, ALL_ONES);
    // even moduli, zero included
    load_modulus(64'd0);
    issue_division(64'd1, 64'd1);
    load_modulus(64'h2A);
    issue_division(64'd5, 64'd3);
    // sparse modulus with the top bit set
    load_modulus(64'h8000_0000_0000_001B);
    issue_division(64'd1, 64'h4000_0000_0000_0000);
    issue_division(64'd1, 64'd1);
    issue_division(64'h7FFF_FFFF_FFFF_FFFF, 64'h1234_5678_9ABC_DEF1);

    // random phases, one modulus each
    kinds = '{MOD_ODD_DEG, MOD_AES, MOD_ODD_FULL, MOD_EVEN, MOD_ONES, MOD_ODD_DEG,
              MOD_SPARSE, MOD_ONE, MOD_ODD_FULL, MOD_ZERO, MOD_ODD_DEG, MOD_AES};
    foreach (kinds[k]) begin
      deg = $urandom_range(2, FIELD_W - 1);
      case (kinds[k])
        MOD_AES:      m = 64'h11B;
        MOD_ONES:     m = ALL_ONES;
        MOD_SPARSE:   m = 64'h8000_0000_0000_001B;
        MOD_ONE:      m = 64'd1;
        MOD_ODD_FULL: m = random_word() | 64'h8000_0000_0000_0001;
        MOD_ODD_DEG:  m = (random_word() & (ALL_ONES >> (FIELD_W - deg)))
                          | (64'd1 << deg) | 64'd1;
        MOD_EVEN:     m = random_word() & ~64'd1;
        default:      m = '0;
      endcase
      load_modulus(m);
      count = (kinds[k] inside {MOD_ONE, MOD_EVEN, MOD_ZERO}) ? 25 : 130;
      for (int n = 0; n < count; n++) begin
        // sender holds off once per phase until the block has drained
        if (n == count / 2) wait_until_quiet();
        issue_division(pick_operand(m), pick_operand(m));
      end
    end

    // drain and finish
    wait_until_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
